// File: rtl/sipq_pkg.sv
`default_nettype none
package sipq_pkg;

  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;
  localparam int SYM_W     = 8;
  localparam int TIE_W     = 8;
  localparam int NODE_W    = 9;
  localparam int IN_FREQ_W = 32;
  localparam int OUT_CNT_W = 10;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  // entry layout: {freq, sym, tie, node}
  localparam int NODE_LSB  = 0;
  localparam int TIE_LSB   = NODE_LSB + NODE_W;
  localparam int SYM_LSB   = TIE_LSB + TIE_W;
  localparam int FREQ_LSB  = SYM_LSB + SYM_W;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_MISS  = 2'd3;

  localparam logic [ADDR_W-3:0] REG_ORDER = 1'b0;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_ROTATE,
    CELL_APPEND
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     by_symbol;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/sipq_cell.sv
`default_nettype none
module sipq_cell import sipq_pkg::*; #(
  parameter int IDX       = 0,
  parameter int FREQ_BITS = 32,
  parameter int CNT_W     = 10,
  parameter int ENT_W     = FREQ_LSB + FREQ_BITS
) (
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl_i,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire logic [CNT_W-1:0] last_i,
  input  wire logic [ENT_W-1:0] new_i,
  input  wire logic [ENT_W-1:0] left_i,
  input  wire logic [ENT_W-1:0] right_i,
  input  wire logic [ENT_W-1:0] head_i,
  input  wire logic             keep_left_i,
  output logic      [ENT_W-1:0] ent_o,
  output logic                  keep_o
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [ENT_W-1:0]     ent_r;
  logic [ENT_W-1:0]     ent_nxt;
  logic                 valid;
  logic                 key_gt;
  logic                 key_eq;
  logic                 tie_gt;
  logic [SYM_W-1:0]     n_sym;
  logic [SYM_W-1:0]     e_sym;
  logic [TIE_W-1:0]     n_tie;
  logic [TIE_W-1:0]     e_tie;
  logic [FREQ_BITS-1:0] n_freq;
  logic [FREQ_BITS-1:0] e_freq;

  assign n_sym  = new_i[SYM_LSB +: SYM_W];
  assign e_sym  = ent_r[SYM_LSB +: SYM_W];
  assign n_tie  = new_i[TIE_LSB +: TIE_W];
  assign e_tie  = ent_r[TIE_LSB +: TIE_W];
  assign n_freq = new_i[FREQ_LSB +: FREQ_BITS];
  assign e_freq = ent_r[FREQ_LSB +: FREQ_BITS];

  assign valid  = IDX_C < count_i;
  assign key_gt = ctl_i.by_symbol ? (n_sym > e_sym) : (n_freq > e_freq);
  assign key_eq = ctl_i.by_symbol ? (n_sym == e_sym) : (n_freq == e_freq);
  assign tie_gt = n_tie > e_tie;
  // new entry belongs after this one
  assign keep_o = valid & (key_gt | (key_eq & tie_gt));
  assign ent_o  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    case (ctl_i.op)
      CELL_HOLD:   ent_nxt = ent_r;
      CELL_INSERT: begin
        if (keep_o) begin
          ent_nxt = ent_r;
        end else if (keep_left_i) begin
          ent_nxt = new_i;
        end else begin
          ent_nxt = left_i;
        end
      end
      CELL_SHIFT:  ent_nxt = right_i;
      CELL_ROTATE: ent_nxt = (IDX_C == last_i) ? head_i : right_i;
      CELL_APPEND: ent_nxt = (IDX_C == count_i) ? new_i : ent_r;
      default:     ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/sipq_ctrl.sv
`default_nettype none
module sipq_ctrl import sipq_pkg::*; #(
  parameter int DEPTH     = 512,
  parameter int FREQ_BITS = 32,
  parameter int CNT_W     = 10,
  parameter int ENT_W     = FREQ_LSB + FREQ_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [REQ_W-1:0]     in_req_type,
  input  wire logic [SYM_W-1:0]     in_symbol,
  input  wire logic [IN_FREQ_W-1:0] in_frequency,
  input  wire logic [TIE_W-1:0]     in_tie_key,
  input  wire logic [NODE_W-1:0]    in_node_id,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [STAT_W-1:0]         out_status,
  output logic [SYM_W-1:0]          out_symbol,
  output logic [IN_FREQ_W-1:0]      out_frequency,
  output logic [TIE_W-1:0]          out_tie_key,
  output logic [NODE_W-1:0]         out_node_id,
  output logic [OUT_CNT_W-1:0]      out_entry_count,
  input  wire logic                 by_symbol_i,
  input  wire logic                 order_change_i,
  input  wire logic [ENT_W-1:0]     head_i,
  input  wire logic                 head_keep_i,
  output cell_ctl_t                 ctl_o,
  output logic [CNT_W-1:0]          count_o,
  output logic [CNT_W-1:0]          last_o,
  output logic [ENT_W-1:0]          new_o
);

  localparam int FX = (FREQ_BITS > IN_FREQ_W) ? FREQ_BITS : IN_FREQ_W;
  localparam int CX = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_INS,
    ST_SCAN_LOOK
  } state_t;

  state_t               state_r, state_nxt;
  logic [REQ_W-1:0]     req_r, req_nxt;
  logic [SYM_W-1:0]     sym_r, sym_nxt;
  logic [FREQ_BITS-1:0] freq_r, freq_nxt;
  logic [TIE_W-1:0]     tie_r, tie_nxt;
  logic [NODE_W-1:0]    node_r, node_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     scan_r, scan_nxt;
  logic                 mark_r, mark_nxt;
  logic                 sorted_r, sorted_nxt;
  logic [ENT_W-1:0]     hit_r, hit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_status_r, out_status_nxt;
  logic [SYM_W-1:0]     out_sym_r, out_sym_nxt;
  logic [IN_FREQ_W-1:0] out_freq_r, out_freq_nxt;
  logic [TIE_W-1:0]     out_tie_r, out_tie_nxt;
  logic [NODE_W-1:0]    out_node_r, out_node_nxt;
  logic [OUT_CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  cell_op_t             op;
  logic                 out_free;
  logic                 finish;
  logic                 fin_has_ent;
  logic [STAT_W-1:0]    fin_status;
  logic [ENT_W-1:0]     fin_ent;
  logic [FX-1:0]        in_freq_x;
  logic [FX-1:0]        fin_freq_x;
  logic [CX-1:0]        cnt_x;

  assign in_freq_x  = FX'(in_frequency);
  assign fin_freq_x = FX'(fin_ent[FREQ_LSB +: FREQ_BITS]);
  assign cnt_x      = CX'(count_nxt);
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    sym_nxt        = sym_r;
    freq_nxt       = freq_r;
    tie_nxt        = tie_r;
    node_nxt       = node_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    mark_nxt       = mark_r;
    sorted_nxt     = sorted_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_sym_nxt    = out_sym_r;
    out_freq_nxt   = out_freq_r;
    out_tie_nxt    = out_tie_r;
    out_node_nxt   = out_node_r;
    out_cnt_nxt    = out_cnt_r;
    op             = CELL_HOLD;
    finish         = 1'b0;
    fin_has_ent    = 1'b0;
    fin_status     = STAT_OK;
    fin_ent        = head_i;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          sym_nxt   = in_symbol;
          freq_nxt  = in_freq_x[FREQ_BITS-1:0];
          tie_nxt   = in_tie_key;
          node_nxt  = in_node_id;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          case (req_r)
            REQ_INSERT: begin
              if (count_r == DEPTH_C) begin
                finish     = 1'b1;
                fin_status = STAT_FULL;
              end else if (sorted_r) begin
                op        = CELL_INSERT;
                count_nxt = count_r + ONE_C;
                finish    = 1'b1;
              end else if (count_r == '0) begin
                op        = CELL_APPEND;
                count_nxt = count_r + ONE_C;
                finish    = 1'b1;
              end else begin
                scan_nxt  = count_r;
                mark_nxt  = 1'b0;
                state_nxt = ST_SCAN_INS;
              end
            end
            REQ_POP: begin
              finish = 1'b1;
              if (count_r == '0) begin
                fin_status = STAT_EMPTY;
              end else begin
                op          = CELL_SHIFT;
                count_nxt   = count_r - ONE_C;
                fin_has_ent = 1'b1;
              end
            end
            REQ_LOOKUP: begin
              if (count_r == '0) begin
                finish     = 1'b1;
                fin_status = STAT_MISS;
              end else begin
                scan_nxt  = count_r;
                mark_nxt  = 1'b0;
                state_nxt = ST_SCAN_LOOK;
              end
            end
            default: finish = 1'b1;
          endcase
        end
      end
      ST_SCAN_INS: begin
        // originals pass head to tail once; the new entry is appended
        // when the first original it must precede reaches the head
        if (scan_r == '0) begin
          if (!mark_r) begin
            op        = CELL_APPEND;
            count_nxt = count_r + ONE_C;
            mark_nxt  = 1'b1;
          end else if (out_free) begin
            finish = 1'b1;
          end
        end else if (!mark_r && !head_keep_i) begin
          op        = CELL_APPEND;
          count_nxt = count_r + ONE_C;
          mark_nxt  = 1'b1;
        end else begin
          op       = CELL_ROTATE;
          scan_nxt = scan_r - ONE_C;
        end
      end
      ST_SCAN_LOOK: begin
        if (scan_r == '0) begin
          if (out_free) begin
            finish      = 1'b1;
            fin_has_ent = mark_r;
            fin_ent     = hit_r;
            fin_status  = mark_r ? STAT_OK : STAT_MISS;
          end
        end else begin
          if (!mark_r && (head_i[SYM_LSB +: SYM_W] == sym_r)) begin
            hit_nxt  = head_i;
            mark_nxt = 1'b1;
          end
          op       = CELL_ROTATE;
          scan_nxt = scan_r - ONE_C;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (finish) begin
      state_nxt      = ST_IDLE;
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_status;
      out_sym_nxt    = fin_has_ent ? fin_ent[SYM_LSB +: SYM_W] : '0;
      out_freq_nxt   = fin_has_ent ? fin_freq_x[IN_FREQ_W-1:0] : '0;
      out_tie_nxt    = fin_has_ent ? fin_ent[TIE_LSB +: TIE_W] : '0;
      out_node_nxt   = fin_has_ent ? fin_ent[NODE_LSB +: NODE_W] : '0;
      out_cnt_nxt    = cnt_x[OUT_CNT_W-1:0];
    end

    // fast insert needs the row in order under the current key
    if (order_change_i && (count_r > ONE_C)) begin
      sorted_nxt = 1'b0;
    end
    if (count_nxt <= ONE_C) begin
      sorted_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      mark_r      <= 1'b0;
      sorted_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      mark_r      <= mark_nxt;
      sorted_r    <= sorted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    sym_r        <= sym_nxt;
    freq_r       <= freq_nxt;
    tie_r        <= tie_nxt;
    node_r       <= node_nxt;
    hit_r        <= hit_nxt;
    out_status_r <= out_status_nxt;
    out_sym_r    <= out_sym_nxt;
    out_freq_r   <= out_freq_nxt;
    out_tie_r    <= out_tie_nxt;
    out_node_r   <= out_node_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_symbol      = out_sym_r;
  assign out_frequency   = out_freq_r;
  assign out_tie_key     = out_tie_r;
  assign out_node_id     = out_node_r;
  assign out_entry_count = out_cnt_r;

  assign ctl_o.op        = op;
  assign ctl_o.by_symbol = by_symbol_i;
  assign count_o         = count_r;
  assign last_o          = count_r - ONE_C;
  assign new_o           = {freq_r, sym_r, tie_r, node_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above depth");

  a_lookup_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_LOOK) |=> $stable(count_r))
    else $error("lookup changed entry count");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_INS || state_r == ST_SCAN_LOOK) |-> (scan_r <= count_r))
    else $error("scan length exceeds entry count");

  a_unsorted_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    !sorted_r |-> (count_r > ONE_C))
    else $error("order flag clear with fewer than two entries");

endmodule
`default_nettype wire

// File: rtl/sorted_insert_priority_queue.sv
`default_nettype none
// Sorted priority queue of up to DEPTH entries held in a row of cells, head
// in cell 0. Each request returns one result beat carrying the status and the
// entry count after the request. Pop, and insert while the row is in order
// under the current key, latch the request, then act once the output is
// free: on insert every cell compares the new entry against its own and
// shifts in parallel, on pop every cell shifts toward the head. Lookup
// rotates the row once through the head cell, one entry a cycle. After
// order_by_symbol changes with two or more entries held, inserts use the
// same rotation until the queue drains to one entry. The row needs no
// clearing after reset. A result waiting at the output does not hold off the
// next request; a request finishes only once the output register is free.
module sorted_insert_priority_queue import sipq_pkg::*; #(
  parameter int DEPTH     = 512,
  parameter int FREQ_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [REQ_W-1:0]     in_req_type,
  input  wire logic [SYM_W-1:0]     in_symbol,
  input  wire logic [IN_FREQ_W-1:0] in_frequency,
  input  wire logic [TIE_W-1:0]     in_tie_key,
  input  wire logic [NODE_W-1:0]    in_node_id,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [STAT_W-1:0]         out_status,
  output logic [SYM_W-1:0]          out_symbol,
  output logic [IN_FREQ_W-1:0]      out_frequency,
  output logic [TIE_W-1:0]          out_tie_key,
  output logic [NODE_W-1:0]         out_node_id,
  output logic [OUT_CNT_W-1:0]      out_entry_count,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_W-1:0]    paddr,
  input  wire logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = FREQ_LSB + FREQ_BITS;

  logic             by_symbol_r, by_symbol_nxt;
  logic             reg_hit;
  logic             cfg_wr;
  logic             order_change;
  cell_ctl_t        ctl;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] last;
  logic [ENT_W-1:0] new_ent;
  logic [ENT_W-1:0] ent   [DEPTH];
  logic [ENT_W-1:0] left  [DEPTH];
  logic [ENT_W-1:0] right [DEPTH];
  logic             keep  [DEPTH];
  logic             keep_left [DEPTH];

  assign pready       = 1'b1;
  assign reg_hit      = (paddr[ADDR_W-1:2] == REG_ORDER);
  assign cfg_wr       = psel && penable && pwrite && pready && reg_hit;
  assign order_change = cfg_wr && (pwdata[0] != by_symbol_r);
  assign by_symbol_nxt = cfg_wr ? pwdata[0] : by_symbol_r;
  assign prdata       = reg_hit ? {{(DATA_W-1){1'b0}}, by_symbol_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      by_symbol_r <= 1'b0;
    end else begin
      by_symbol_r <= by_symbol_nxt;
    end
  end

  sipq_ctrl #(
    .DEPTH     (DEPTH),
    .FREQ_BITS (FREQ_BITS),
    .CNT_W     (CNT_W),
    .ENT_W     (ENT_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_symbol       (in_symbol),
    .in_frequency    (in_frequency),
    .in_tie_key      (in_tie_key),
    .in_node_id      (in_node_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_symbol      (out_symbol),
    .out_frequency   (out_frequency),
    .out_tie_key     (out_tie_key),
    .out_node_id     (out_node_id),
    .out_entry_count (out_entry_count),
    .by_symbol_i     (by_symbol_r),
    .order_change_i  (order_change),
    .head_i          (ent[0]),
    .head_keep_i     (keep[0]),
    .ctl_o           (ctl),
    .count_o         (count),
    .last_o          (last),
    .new_o           (new_ent)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left[i]      = new_ent;
      assign keep_left[i] = 1'b1;
    end else begin : g_inner
      assign left[i]      = ent[i-1];
      assign keep_left[i] = keep[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right[i] = ent[i];
    end else begin : g_mid
      assign right[i] = ent[i+1];
    end

    sipq_cell #(
      .IDX       (i),
      .FREQ_BITS (FREQ_BITS),
      .CNT_W     (CNT_W),
      .ENT_W     (ENT_W)
    ) u_cell (
      .clk         (clk),
      .ctl_i       (ctl),
      .count_i     (count),
      .last_i      (last),
      .new_i       (new_ent),
      .left_i      (left[i]),
      .right_i     (right[i]),
      .head_i      (ent[0]),
      .keep_left_i (keep_left[i]),
      .ent_o       (ent[i]),
      .keep_o      (keep[i])
    );
  end

endmodule
`default_nettype wire
